@@ rtl/pdpf_pkg.sv @@
// ============================================================================
// pdpf_pkg: shared types, constants and lane arithmetic
// Holds the pixel geometry, the configuration register indexes and the
// per-lane Paeth predictor used by the pixel filter datapath.
// ============================================================================
package pdpf_pkg;

    localparam int LANES  = 4;
    localparam int LANE_W = 8;
    localparam int PIX_W  = LANES * LANE_W;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION      = 2'd0,
        CFG_PREDICT_ENABLE = 2'd1,
        CFG_IMAGE_WIDTH    = 2'd2
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET = 13'd256;

    // Row position flags of one pixel, carried from the position tracker
    // down the pipeline.
    typedef struct packed {
        logic first_row;
        logic last;
    } t_row_flags;

    // Paeth predictor on one byte lane.
    function automatic logic [LANE_W-1:0] paeth_lane(
        input logic [LANE_W-1:0] a,
        input logic [LANE_W-1:0] b,
        input logic [LANE_W-1:0] c
    );
        logic signed [LANE_W+1:0] p;
        logic signed [LANE_W+1:0] da;
        logic signed [LANE_W+1:0] db;
        logic signed [LANE_W+1:0] dc;
        logic [LANE_W+1:0]        pa;
        logic [LANE_W+1:0]        pb;
        logic [LANE_W+1:0]        pc;
        logic [LANE_W-1:0]        sel;
        p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
        da = p - $signed({2'b00, a});
        db = p - $signed({2'b00, b});
        dc = p - $signed({2'b00, c});
        pa = da[LANE_W+1] ? $unsigned(-da) : $unsigned(da);
        pb = db[LANE_W+1] ? $unsigned(-db) : $unsigned(db);
        pc = dc[LANE_W+1] ? $unsigned(-dc) : $unsigned(dc);
        if (pa <= pb && pa <= pc) begin
            sel = a;
        end else if (pb <= pc) begin
            sel = b;
        end else begin
            sel = c;
        end
        return sel;
    endfunction

endpackage

@@ rtl/pdpf_line_store.sv @@
// ============================================================================
// pdpf_line_store: previous-row pixel memory
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read enable. A read of the entry written in the same
// cycle returns the old contents.
// ============================================================================
module pdpf_line_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [pdpf_pkg::PIX_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [pdpf_pkg::PIX_W-1:0]  o_rdata
);
    import pdpf_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pdpf_position.sv @@
// ============================================================================
// pdpf_position: raster position tracker
// Works out the column and row flags of each accepted pixel from the
// configured width and the frame-start flag, and advances the count.
// ============================================================================
module pdpf_position #(
    parameter int MAX_WIDTH = 4096,
    parameter int CNT_W     = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_first_of_frame,
    input  logic [pdpf_pkg::CFG_DATA_W-1:0]   i_image_width,
    output logic [CNT_W-1:0]                  o_col,
    output pdpf_pkg::t_row_flags              o_flags
);
    import pdpf_pkg::*;

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] n_col;
    logic             r_first_row;
    logic             n_first_row;

    logic [31:0]      width_clamped;
    logic [CNT_W-1:0] width_eff;
    logic [CNT_W-1:0] col_base;
    logic             first_base;
    logic [CNT_W-1:0] col;
    logic             first_row;
    logic             last;

    always_comb begin
        if (i_image_width == '0) begin
            width_clamped = 32'd1;
        end else if ({{(32-CFG_DATA_W){1'b0}}, i_image_width} > 32'(MAX_WIDTH)) begin
            width_clamped = 32'(MAX_WIDTH);
        end else begin
            width_clamped = {{(32-CFG_DATA_W){1'b0}}, i_image_width};
        end
        width_eff = width_clamped[CNT_W-1:0];

        col_base   = i_first_of_frame ? '0 : r_col;
        first_base = i_first_of_frame ? 1'b1 : r_first_row;

        // A width that shrank under the current column starts a new row.
        if (col_base >= width_eff) begin
            col       = '0;
            first_row = 1'b0;
        end else begin
            col       = col_base;
            first_row = first_base;
        end

        last = (col + CNT_W'(1)) == width_eff;

        if (last) begin
            n_col       = '0;
            n_first_row = 1'b0;
        end else begin
            n_col       = col + CNT_W'(1);
            n_first_row = first_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else if (i_accept) begin
            r_col       <= n_col;
            r_first_row <= n_first_row;
        end
    end

    assign o_col             = col;
    assign o_flags.first_row = first_row;
    assign o_flags.last      = last;

endmodule

@@ rtl/pdpf_predict.sv @@
// ============================================================================
// pdpf_predict: per-lane Paeth prediction and residual arithmetic
// Computes the filtered or rebuilt pixel from the neighbours, and the
// original-image pixel that becomes the neighbour of later pixels.
// ============================================================================
module pdpf_predict (
    input  logic                        i_direction,
    input  logic                        i_predict_enable,
    input  logic [pdpf_pkg::PIX_W-1:0]  i_left,
    input  logic [pdpf_pkg::PIX_W-1:0]  i_up,
    input  logic [pdpf_pkg::PIX_W-1:0]  i_upleft,
    input  logic [pdpf_pkg::PIX_W-1:0]  i_data,
    input  logic [pdpf_pkg::PIX_W-1:0]  i_ref,
    output logic [pdpf_pkg::PIX_W-1:0]  o_result,
    output logic [pdpf_pkg::PIX_W-1:0]  o_orig
);
    import pdpf_pkg::*;

    logic [PIX_W-1:0] result;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [LANE_W-1:0] pred;
        logic [LANE_W-1:0] d;
        logic [LANE_W-1:0] r;

        assign d    = i_data[k*LANE_W +: LANE_W];
        assign r    = i_ref[k*LANE_W +: LANE_W];
        assign pred = i_predict_enable
                    ? paeth_lane(i_left[k*LANE_W +: LANE_W],
                                 i_up[k*LANE_W +: LANE_W],
                                 i_upleft[k*LANE_W +: LANE_W])
                    : '0;
        assign result[k*LANE_W +: LANE_W] = i_direction ? (r + pred + d) : (d - r - pred);
    end

    assign o_result = result;
    assign o_orig   = i_direction ? result : i_data;

endmodule

@@ rtl/paeth_delta_pixel_filter.sv @@
// ============================================================================
// paeth_delta_pixel_filter: RGBA8 Paeth delta filter and reconstructor
// Filters pixels against a reference frame and the Paeth prediction of
// their original-image neighbours, or rebuilds pixels from residuals.
// ============================================================================
//
//   Channel  Valid        Ready        Payload
//   -------  -----------  -----------  ---------------------------------------
//   input    i_in_valid   o_in_ready   i_data_pixel, i_ref_pixel,
//                                      i_first_of_frame
//   output   o_out_valid  i_out_ready  o_result_pixel, o_row_end
//   config   i_cfg_we     (none)       i_cfg_idx, i_cfg_data
//
// One pixel per cycle while the output is not stalled; a pixel's result passes
// the line store read into stage 1, then prediction into the output register.
// The per-pixel rate is set by the loop from one pixel's result into the left
// neighbour of the next, closed through the r_left register; the previous-row
// entry of a column written in the cycle it is read is forwarded.
// Reset is synchronous; the line store is not cleared and needs no pass.
// A stalled output holds the pipeline; input is taken while a slot is free.
// ============================================================================
module paeth_delta_pixel_filter #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_cfg_we,
    input  logic [pdpf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pdpf_pkg::CFG_DATA_W-1:0]    i_cfg_data,

    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [pdpf_pkg::PIX_W-1:0]         i_data_pixel,
    input  logic [pdpf_pkg::PIX_W-1:0]         i_ref_pixel,
    input  logic                               i_first_of_frame,

    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [pdpf_pkg::PIX_W-1:0]         o_result_pixel,
    output logic                               o_row_end
);
    import pdpf_pkg::*;

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);

    // Configuration registers.
    logic                  r_direction;
    logic                  r_predict_enable;
    logic [CFG_DATA_W-1:0] r_image_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction      <= 1'b0;
            r_predict_enable <= 1'b1;
            r_image_width    <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DIRECTION:      r_direction      <= i_cfg_data[0];
                CFG_PREDICT_ENABLE: r_predict_enable <= i_cfg_data[0];
                CFG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control.
    logic       r_s1_valid;
    logic       r_out_valid;
    logic       s1_adv;
    logic       in_accept;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    // Stage 0: position and line store read.
    logic [CNT_W-1:0] s0_col;
    t_row_flags       s0_flags;

    pdpf_position #(
        .MAX_WIDTH (MAX_WIDTH),
        .CNT_W     (CNT_W)
    ) u_position (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_first_of_frame (i_first_of_frame),
        .i_image_width    (r_image_width),
        .o_col            (s0_col),
        .o_flags          (s0_flags)
    );

    // Stage 1 registers.
    logic [PIX_W-1:0] r_s1_data;
    logic [PIX_W-1:0] r_s1_ref;
    logic [CNT_W-1:0] r_s1_col;
    t_row_flags       r_s1_flags;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_pixel;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_upleft;

    logic [PIX_W-1:0] mem_rdata;
    logic [PIX_W-1:0] s1_result;
    logic [PIX_W-1:0] s1_orig;
    logic [PIX_W-1:0] up_raw;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] upleft;
    logic             col_nz;

    pdpf_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col[ADDR_W-1:0]),
        .i_wdata (s1_orig),
        .i_re    (in_accept),
        .i_raddr (s0_col[ADDR_W-1:0]),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_data   <= i_data_pixel;
            r_s1_ref    <= i_ref_pixel;
            r_s1_col    <= s0_col;
            r_s1_flags  <= s0_flags;
            // The pixel ahead writes the entry this read sees as stale.
            r_fwd       <= s1_adv && (r_s1_col == s0_col);
            r_fwd_pixel <= s1_orig;
        end
    end

    always_comb begin
        col_nz = r_s1_col != '0;
        up_raw = r_fwd ? r_fwd_pixel : mem_rdata;
        up     = r_s1_flags.first_row ? '0 : up_raw;
        left   = col_nz ? r_left : '0;
        upleft = (col_nz && !r_s1_flags.first_row) ? r_upleft : '0;
    end

    pdpf_predict u_predict (
        .i_direction      (r_direction),
        .i_predict_enable (r_predict_enable),
        .i_left           (left),
        .i_up             (up),
        .i_upleft         (upleft),
        .i_data           (r_s1_data),
        .i_ref            (r_s1_ref),
        .o_result         (s1_result),
        .o_orig           (s1_orig)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_upleft <= '0;
        end else if (s1_adv) begin
            r_left   <= s1_orig;
            r_upleft <= up;
        end
    end

    // Output register.
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pixel   <= s1_result;
            r_out_row_end <= r_s1_flags.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_pixel = r_out_pixel;
    assign o_row_end      = r_out_row_end;

endmodule

@@ rtl/pdpf_checker.sv @@
// ============================================================================
// pdpf_checker: port-level checks for the Paeth delta pixel filter
// Watches the handshakes on the top level's ports and tracks the number of
// transactions in flight.
// ============================================================================
module pdpf_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [pdpf_pkg::PIX_W-1:0]  o_result_pixel,
    input  logic                        o_row_end
);
    import pdpf_pkg::*;

    logic [1:0] r_pend;
    logic       in_txn;
    logic       out_txn;

    assign in_txn  = i_in_valid && o_in_ready;
    assign out_txn = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_txn} - {1'b0, out_txn};
        end
    end

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_txn |-> r_pend != 2'd0)
        else $error("result transaction without a pending input");

    a_in_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'd2)
        else $error("more than two transactions in flight");

    a_stall_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_result_pixel) && $stable(o_row_end)))
        else $error("stalled result changed");

endmodule

bind paeth_delta_pixel_filter pdpf_checker u_pdpf_checker (.*);

@@ test/tb.sv @@
// ============================================================================
// tb: self-checking bench for paeth_delta_pixel_filter
// Drives RGBA8 pixels with their reference pixels through valid/ready,
// gets results from its own Paeth delta predictor or a directed row, compares
// each output transaction, pixel and row flag, against the oldest one pending.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdpf_pkg::*;

    localparam int LINE_DEPTH    = 4096;
    localparam int ITEM_TARGET   = 1050;
    localparam int CALM_ITEMS    = 150;
    localparam int HOLD_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DIRECTED_ROWS = 25;

    // One bit per configuration register, indexed by t_cfg_idx.
    localparam logic [2:0] SET_NONE  = 3'b000;
    localparam logic [2:0] SET_DIR   = 3'b001;
    localparam logic [2:0] SET_PRED  = 3'b010;
    localparam logic [2:0] SET_WIDTH = 3'b100;
    localparam logic [2:0] SET_ALL   = 3'b111;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             row_end;
    } t_pixel_result;

    typedef struct packed {
        logic [2:0]            regs;
        logic                  dir;
        logic                  pen;
        logic [CFG_DATA_W-1:0] width;
        logic [PIX_W-1:0]      data;
        logic [PIX_W-1:0]      refp;
        logic                  fof;
        logic                  typed;
        logic [PIX_W-1:0]      want_pix;
        logic                  want_end;
    } t_stim_row;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic [PIX_W-1:0]      i_data_pixel     = '0;
    logic [PIX_W-1:0]      i_ref_pixel      = '0;
    logic                  i_first_of_frame = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic [PIX_W-1:0]      o_result_pixel;
    logic                  o_row_end;

    paeth_delta_pixel_filter #(
        .MAX_WIDTH(LINE_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_pixel     (i_data_pixel),
        .i_ref_pixel      (i_ref_pixel),
        .i_first_of_frame (i_first_of_frame),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_pixel   (o_result_pixel),
        .o_row_end        (o_row_end)
    );

    // Predictor state: original pixels of the previous row and the neighbours.
    logic [PIX_W-1:0]      line_mem [LINE_DEPTH];
    bit                    line_written [LINE_DEPTH];
    logic [PIX_W-1:0]      left_pix;
    logic [PIX_W-1:0]      diag_pix;
    int                    col_pos;
    bit                    top_row;
    bit                    cfg_recon;
    bit                    cfg_paeth;
    logic [CFG_DATA_W-1:0] cfg_width;
    bit                    force_frame;

    t_pixel_result pending_results[$];
    t_pixel_result want;
    int            mismatches   = 0;
    int            results_seen = 0;
    int            cycle_count  = 0;
    int            stall_left   = 0;
    bit            hold_request = 1'b0;
    bit            calm         = 1'b0;

    t_stim_row directed [DIRECTED_ROWS] = '{
        '{SET_NONE,  1'b0, 1'b1, 13'd256,  32'hFFFFFFFF, 32'h00000000, 1'b0,
          1'b1, 32'hFFFFFFFF, 1'b0},
        '{SET_NONE,  1'b0, 1'b1, 13'd256,  32'h00000000, 32'hFFFFFFFF, 1'b1,
          1'b1, 32'h01010101, 1'b0},
        '{SET_NONE,  1'b0, 1'b1, 13'd256,  32'h80808080, 32'h00000000, 1'b0,
          1'b1, 32'h80808080, 1'b0},
        '{SET_NONE,  1'b0, 1'b1, 13'd256,  32'h7F00FF01, 32'h12345678, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_NONE,  1'b0, 1'b1, 13'd256,  32'h00FF00FF, 32'hFF00FF00, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_WIDTH, 1'b0, 1'b1, 13'd1,    32'hA5A5A5A5, 32'h00000000, 1'b1,
          1'b1, 32'hA5A5A5A5, 1'b1},
        '{SET_NONE,  1'b0, 1'b1, 13'd1,    32'h5A5A5A5A, 32'h01020304, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_WIDTH, 1'b0, 1'b1, 13'd0,    32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_ALL,   1'b1, 1'b1, 13'd3,    32'h01020304, 32'h10203040, 1'b1,
          1'b1, 32'h11223344, 1'b0},
        '{SET_NONE,  1'b1, 1'b1, 13'd3,    32'h00FF7F80, 32'h80808080, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_NONE,  1'b1, 1'b1, 13'd3,    32'hFF00807F, 32'h01010101, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_NONE,  1'b1, 1'b1, 13'd3,    32'h7F7F7F7F, 32'h00000000, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_NONE,  1'b1, 1'b1, 13'd3,    32'h80018002, 32'hFFFFFFFF, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_NONE,  1'b1, 1'b1, 13'd3,    32'h00000000, 32'h00000000, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_PRED,  1'b1, 1'b0, 13'd3,    32'h01010101, 32'hFFFFFFFF, 1'b1,
          1'b1, 32'h00000000, 1'b0},
        '{SET_DIR,   1'b0, 1'b0, 13'd3,    32'h00000000, 32'h01010101, 1'b1,
          1'b1, 32'hFFFFFFFF, 1'b0},
        '{SET_ALL,   1'b0, 1'b1, 13'd8,    32'h11111111, 32'h00000000, 1'b1,
          1'b1, 32'h11111111, 1'b0},
        '{SET_NONE,  1'b0, 1'b1, 13'd8,    32'h12345678, 32'h00000000, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_NONE,  1'b0, 1'b1, 13'd8,    32'h2222FFEE, 32'h01010101, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_NONE,  1'b0, 1'b1, 13'd8,    32'hFFFFFFFF, 32'h00000000, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_NONE,  1'b0, 1'b1, 13'd8,    32'h00000000, 32'hFFFFFFFF, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_WIDTH, 1'b0, 1'b1, 13'd3,    32'h33333333, 32'h00000000, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_NONE,  1'b0, 1'b1, 13'd3,    32'hC0C0C0C0, 32'h40404040, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_WIDTH, 1'b0, 1'b1, 13'd8191, 32'hDEADBEEF, 32'h00000000, 1'b0,
          1'b0, 32'h0, 1'b0},
        '{SET_WIDTH, 1'b0, 1'b1, 13'd4096, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b0,
          1'b0, 32'h0, 1'b0}
    };

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d results pending", pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int eff_width(input logic [CFG_DATA_W-1:0] w);
        if (w == 0) return 1;
        if (w > LINE_DEPTH) return LINE_DEPTH;
        return int'(w);
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
        int est;
        int da;
        int db;
        int dc;
        est = int'(a) + int'(b) - int'(c);
        da = est - int'(a);
        db = est - int'(b);
        dc = est - int'(c);
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    // Works out the result of one pixel transaction and advances the position
    // tracker and neighbour registers the way the block does.
    function automatic void predict_result(input logic [PIX_W-1:0] data_in,
                                           input logic [PIX_W-1:0] ref_in,
                                           input logic fof,
                                           output logic [PIX_W-1:0] res,
                                           output logic last_px);
        int               ew;
        int               col;
        logic [PIX_W-1:0] left_n;
        logic [PIX_W-1:0] up_n;
        logic [PIX_W-1:0] diag_n;
        logic [PIX_W-1:0] orig;
        logic [7:0]       pred;
        ew = eff_width(cfg_width);
        if (fof) begin
            col_pos = 0;
            top_row = 1'b1;
        end
        // A width that shrank below the current column starts a new row.
        if (col_pos >= ew) begin
            col_pos = 0;
            top_row = 1'b0;
        end
        col = col_pos;
        left_n = (col > 0) ? left_pix : '0;
        up_n = top_row ? '0 : line_mem[col];
        diag_n = (col > 0 && !top_row) ? diag_pix : '0;
        for (int k = 0; k < LANES; k++) begin
            pred = cfg_paeth ? paeth_pick(left_n[8*k +: 8], up_n[8*k +: 8], diag_n[8*k +: 8])
                             : 8'd0;
            if (cfg_recon) begin
                res[8*k +: 8] = ref_in[8*k +: 8] + pred + data_in[8*k +: 8];
            end else begin
                res[8*k +: 8] = data_in[8*k +: 8] - ref_in[8*k +: 8] - pred;
            end
        end
        orig = cfg_recon ? res : data_in;
        line_mem[col] = orig;
        line_written[col] = 1'b1;
        left_pix = orig;
        diag_pix = up_n;
        last_px = (col + 1 == ew);
        if (last_px) begin
            col_pos = 0;
            top_row = 1'b0;
        end else begin
            col_pos = col + 1;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] exp_val);
        $display("result %0d: %s is %h, expected %h", results_seen, what, got, exp_val);
        mismatches++;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the selected registers once the pipeline is empty. A width whose
    // line store span is not fully written forces the next pixel to open a
    // frame, so no row ever reads a line store entry that was never filled.
    task automatic program_regs(input logic [2:0] regs, input logic dir, input logic pen,
                                input logic [CFG_DATA_W-1:0] w);
        t_cfg_idx reg_idx;
        int       ew;
        i_in_valid <= 1'b0;
        drain_results();
        for (int i = 0; i < 3; i++) begin
            reg_idx = t_cfg_idx'(i);
            if (regs[i]) begin
                i_cfg_we  <= 1'b1;
                i_cfg_idx <= reg_idx;
                case (reg_idx)
                    CFG_DIRECTION: begin
                        i_cfg_data <= CFG_DATA_W'(dir);
                        cfg_recon = dir;
                    end
                    CFG_PREDICT_ENABLE: begin
                        i_cfg_data <= CFG_DATA_W'(pen);
                        cfg_paeth = pen;
                    end
                    CFG_IMAGE_WIDTH: begin
                        i_cfg_data <= w;
                        cfg_width = w;
                    end
                    default: ;
                endcase
                @(posedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
        if (regs[CFG_IMAGE_WIDTH]) begin
            ew = eff_width(cfg_width);
            for (int i = 0; i < ew; i++) begin
                if (!line_written[i]) force_frame = 1'b1;
            end
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] data_in, input logic [PIX_W-1:0] ref_in,
                              input logic fof, input logic typed,
                              input logic [PIX_W-1:0] want_pix, input logic want_end);
        logic [PIX_W-1:0] res;
        logic             last_px;
        t_pixel_result    entry;
        fof = fof | force_frame;
        force_frame = 1'b0;
        i_in_valid       <= 1'b1;
        i_data_pixel     <= data_in;
        i_ref_pixel      <= ref_in;
        i_first_of_frame <= fof;
        do @(posedge i_clk); while (!o_in_ready);
        predict_result(data_in, ref_in, fof, res, last_px);
        entry.pix = typed ? want_pix : res;
        entry.row_end = typed ? want_end : last_px;
        pending_results.push_back(entry);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Output side: checks each transaction and stalls in bursts, or for one
    // long hold-off when the stimulus asks for it.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result_pixel", o_result_pixel, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_result_pixel !== want.pix) begin
                    report_mismatch("result_pixel", o_result_pixel, want.pix);
                end
                if (o_row_end !== want.row_end) begin
                    report_mismatch("row_end", PIX_W'(o_row_end), PIX_W'(want.row_end));
                end
            end
        end
        if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(0, 8);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        int                    random_sent;
        int                    phase;
        int                    phase_len;
        int                    style;
        logic [CFG_DATA_W-1:0] w;
        logic [PIX_W-1:0]      pix;
        logic [PIX_W-1:0]      refv;
        logic                  fof;

        left_pix    = '0;
        diag_pix    = '0;
        col_pos     = 0;
        top_row     = 1'b1;
        cfg_recon   = 1'b0;
        cfg_paeth   = 1'b1;
        cfg_width   = WIDTH_RESET;
        force_frame = 1'b0;
        for (int i = 0; i < LINE_DEPTH; i++) line_written[i] = 1'b0;
        random_sent = 0;
        phase = 0;
        pix = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r]) begin
            if (directed[r].regs != SET_NONE) begin
                program_regs(directed[r].regs, directed[r].dir, directed[r].pen,
                             directed[r].width);
            end
            send_pixel(directed[r].data, directed[r].refp, directed[r].fof,
                       directed[r].typed, directed[r].want_pix, directed[r].want_end);
        end

        while (random_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9)) inside
                0:       w = 13'd0;
                1:       w = 13'd1;
                [2:6]:   w = CFG_DATA_W'($urandom_range(2, 16));
                [7:8]:   w = CFG_DATA_W'($urandom_range(17, 64));
                default: w = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
            endcase
            program_regs(3'($urandom_range(1, 7)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) != 0, w);
            // Very wide rows stay short so the run does not stretch out.
            phase_len = (eff_width(cfg_width) > 64) ? $urandom_range(10, 30)
                                                    : $urandom_range(40, 140);
            if ($urandom_range(0, 1) == 1) force_frame = 1'b1;
            style = $urandom_range(0, 2);
            for (int n = 0; n < phase_len && random_sent < ITEM_TARGET; n++) begin
                if (random_sent == ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
                if (phase == 2 && n == 5) hold_request = 1'b1;
                case (style)
                    0: pix = $urandom;
                    1: begin
                        for (int k = 0; k < LANES; k++) begin
                            pix[8*k +: 8] = pix[8*k +: 8] + 8'($urandom_range(0, 6)) - 8'd3;
                        end
                    end
                    default: begin
                        if ($urandom_range(0, 15) == 0) pix = $urandom;
                    end
                endcase
                case ($urandom_range(0, 3))
                    0:       refv = '0;
                    1:       refv = $urandom;
                    2:       refv = pix;
                    default: refv = pix ^ 32'($urandom_range(0, 255));
                endcase
                fof = ($urandom_range(0, 63) == 0);
                send_pixel(pix, refv, fof, 1'b0, '0, 1'b0);
                random_sent++;
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
